[rtl/sba_pkg.sv]
// Shared types and codes for the segmented block allocator.
// No dependencies; used by the top level.
package sba_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_FRD,
        S_FCHK,
        S_DONE
    } t_state;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_DONE         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE     = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE     = 2'd2;
    localparam logic [1:0] STATUS_FREE_IGNORED = 2'd3;

    localparam int HDR_W      = 13;
    localparam int ALLOC_BIT  = 12;
    localparam int SIZE_W     = 12;
    localparam int WORDS_W    = 11;

endpackage

[rtl/segmented_block_allocator_unit.sv]
// Top level of the segmented block allocator: request sequencer and header walk.
// Depends on sba_pkg and sba_heap_store.
//
// After reset the header store is cleared, and during the sweep no request is taken.
// An allocate does one RAM read and one check on the shared position adder
// for each header visited in each segment tried; a zero size skips the walk.
// A free reads and checks one header, or skips both when out of range. One
// request is in work at a time; its result waits in an output register so the
// next request can be taken while it is pending.
module segmented_block_allocator_unit #(
    parameter int SEG_WORDS = 1024,
    parameter int NUM_SEGS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] byte_count, [15:12] segment, [27:16] byte_offset
    input  logic [31:0] i_s_axis_tdata,
    // [0] cmd
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [5:2] result_segment, [17:6] result_offset
    output logic [23:0] o_m_axis_tdata
);
    localparam int DEPTH = SEG_WORDS * NUM_SEGS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(SEG_WORDS + 2048);
    localparam int HW    = sba_pkg::HDR_W;
    localparam int WW    = sba_pkg::WORDS_W;

    sba_pkg::t_state r_state, n_state;

    logic          r_cmd;
    logic [11:0]   r_bytes, n_bytes;
    logic [WW-1:0] r_want, n_want;
    logic [3:0]    r_seg, n_seg;
    logic [PW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_addr, n_addr;
    logic [1:0]    r_status, n_status;
    logic [3:0]    r_rseg, n_rseg;
    logic [11:0]   r_roff, n_roff;
    logic          r_ovalid;
    logic [23:0]   r_odata;

    logic          w_accept;
    logic          w_mem_ready;
    logic [HW-1:0] w_rdata;
    logic          w_we;
    logic [HW-1:0] w_wdata;

    logic [11:0]   w_in_bytes;
    logic [3:0]    w_in_seg;
    logic [9:0]    w_in_word;
    logic [12:0]   w_in_round;
    logic          w_free_oob;

    logic [11:0]   w_sz;
    logic [12:0]   w_sz_round;
    logic [WW-1:0] w_sz_words;
    logic          w_hit;
    logic [WW-1:0] w_operand;
    logic [PW-1:0] w_sum;
    logic          w_seg_end;
    logic          w_last_seg;
    logic          w_fit_ok;
    logic          w_free_ok;
    logic          w_out_free;

    assign w_accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_in_bytes = i_s_axis_tdata[11:0];
    assign w_in_seg   = i_s_axis_tdata[15:12];
    assign w_in_word  = i_s_axis_tdata[27:18];
    assign w_in_round = {1'b0, w_in_bytes} + 13'd3;
    assign w_free_oob = ({1'b0, w_in_seg} >= 5'(NUM_SEGS))
                      | (PW'(w_in_word) >= PW'(SEG_WORDS));

    // shared position adder: next header on a miss, fit check on a hit
    assign w_sz       = w_rdata[11:0];
    assign w_sz_round = {1'b0, w_sz} + 13'd3;
    assign w_sz_words = w_sz_round[12:2];
    assign w_hit      = (w_sz == '0) | ((w_sz_words == r_want) & ~w_rdata[sba_pkg::ALLOC_BIT]);
    assign w_operand  = w_hit ? r_want : w_sz_words;
    assign w_sum      = r_pos + PW'(w_operand) + PW'(1);
    assign w_fit_ok   = w_sum <= PW'(SEG_WORDS);
    assign w_seg_end  = w_hit ? ~w_fit_ok : (w_sum >= PW'(SEG_WORDS));
    assign w_last_seg = r_seg == 4'(NUM_SEGS - 1);
    assign w_free_ok  = w_rdata[sba_pkg::ALLOC_BIT] & (w_sz != '0);
    assign w_out_free = ~r_ovalid | i_m_axis_tready;

    sba_heap_store #(
        .DEPTH  (DEPTH),
        .DATA_W (HW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (r_addr),
        .i_we    (w_we),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata),
        .o_ready (w_mem_ready)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sba_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == sba_pkg::CMD_ALLOC) begin
                        n_state = (w_in_bytes == '0) ? sba_pkg::S_DONE : sba_pkg::S_ARD;
                    end else begin
                        n_state = w_free_oob ? sba_pkg::S_DONE : sba_pkg::S_FRD;
                    end
                end
            end
            sba_pkg::S_ARD:  n_state = sba_pkg::S_ACHK;
            sba_pkg::S_ACHK: begin
                if ((w_hit & ~w_seg_end) | (w_seg_end & w_last_seg)) begin
                    n_state = sba_pkg::S_DONE;
                end else begin
                    n_state = sba_pkg::S_ARD;
                end
            end
            sba_pkg::S_FRD:  n_state = sba_pkg::S_FCHK;
            sba_pkg::S_FCHK: n_state = sba_pkg::S_DONE;
            sba_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = sba_pkg::S_IDLE;
                end
            end
            default: n_state = sba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == sba_pkg::S_IDLE) & w_mem_ready;
        w_we     = 1'b0;
        w_wdata  = {1'b1, r_bytes};
        n_bytes  = r_bytes;
        n_want   = r_want;
        n_seg    = r_seg;
        n_pos    = r_pos;
        n_base   = r_base;
        n_addr   = r_addr;
        n_status = r_status;
        n_rseg   = r_rseg;
        n_roff   = r_roff;
        case (r_state)
            sba_pkg::S_IDLE: begin
                n_bytes  = w_in_bytes;
                n_want   = w_in_round[12:2];
                n_seg    = '0;
                n_pos    = '0;
                n_base   = '0;
                n_rseg   = '0;
                n_roff   = '0;
                n_status = sba_pkg::STATUS_DONE;
                if (i_s_axis_tuser == sba_pkg::CMD_ALLOC) begin
                    n_addr = '0;
                    if (w_in_bytes == '0) begin
                        n_status = sba_pkg::STATUS_BAD_SIZE;
                    end
                end else begin
                    n_addr = AW'(w_in_seg) * AW'(SEG_WORDS) + AW'(w_in_word);
                    if (w_free_oob) begin
                        n_status = sba_pkg::STATUS_FREE_IGNORED;
                    end
                end
            end
            sba_pkg::S_ACHK: begin
                if (w_seg_end) begin
                    n_seg  = r_seg + 4'd1;
                    n_pos  = '0;
                    n_base = r_base + AW'(SEG_WORDS);
                    n_addr = r_base + AW'(SEG_WORDS);
                    if (w_last_seg) begin
                        n_status = sba_pkg::STATUS_NO_SPACE;
                    end
                end else if (w_hit) begin
                    w_we    = 1'b1;
                    w_wdata = {1'b1, r_bytes};
                    n_rseg  = r_seg;
                    n_roff  = {r_pos[9:0], 2'b00};
                end else begin
                    n_pos  = w_sum;
                    n_addr = r_addr + AW'(w_operand) + AW'(1);
                end
            end
            sba_pkg::S_FCHK: begin
                if (w_free_ok) begin
                    w_we    = 1'b1;
                    w_wdata = {1'b0, w_sz};
                end else begin
                    n_status = sba_pkg::STATUS_FREE_IGNORED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sba_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sba_pkg::S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_axis_tuser;
        end
        r_bytes  <= n_bytes;
        r_want   <= n_want;
        r_seg    <= n_seg;
        r_pos    <= n_pos;
        r_base   <= n_base;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_rseg   <= n_rseg;
        r_roff   <= n_roff;
        if (r_state == sba_pkg::S_DONE && w_out_free) begin
            // free requests report no segment or offset
            if (r_cmd == sba_pkg::CMD_FREE) begin
                r_odata <= {6'd0, 12'd0, 4'd0, r_status};
            end else begin
                r_odata <= {6'd0, r_roff, r_rseg, r_status};
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

[rtl/sba_heap_store.sv]
// Header store of the allocator: RAM with registered read data at i_addr and
// a clearing sweep after reset that writes at its own address. No package dependencies.
module sba_heap_store #(
    parameter int DEPTH  = 16384,
    parameter int DATA_W = 13
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata,
    output logic                     o_ready
);
    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     n_clr_addr;
    logic              r_clearing;
    logic              n_clearing;
    logic [AW-1:0]     w_waddr;
    logic              w_wen;
    logic [DATA_W-1:0] w_wdata;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clearing <= n_clearing;
        end
    end

    assign w_waddr = r_clearing ? r_clr_addr : i_addr;
    assign w_wen   = r_clearing | i_we;
    assign w_wdata = r_clearing ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = ~r_clearing;

endmodule
